// ===== rtl/core/scba_pkg.sv =====
// shared types, class tables and codes of the size class bitmap allocator
package scba_pkg;

    localparam int NUM_CLASSES   = 7;
    localparam int MAP_WORD_BITS = 64;
    localparam int TOTAL_BLOCKS  = 2688;
    localparam int MAP_WORDS     = (TOTAL_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int ADDR_W      = 64;
    localparam int SIZE_W      = 32;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int BIT_POS_W   = $clog2(MAP_WORD_BITS);
    localparam int WORD_ADDR_W = $clog2(MAP_WORDS);
    localparam int COUNT_W     = 10;
    localparam int INDEX_W     = 9;
    localparam int OFS_W       = 22;
    localparam int SHIFT_W     = 4;
    localparam int WLEFT_W     = 4;

    typedef logic [MAP_WORD_BITS-1:0] t_map_word;
    typedef logic [BIT_POS_W-1:0]     t_bit_pos;
    typedef logic [WORD_ADDR_W-1:0]   t_word_addr;
    typedef logic [CLASS_W-1:0]       t_class;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [INDEX_W-1:0]       t_block_idx;
    typedef logic [OFS_W-1:0]         t_pool_ofs;
    typedef logic [WLEFT_W-1:0]       t_words_left;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_EXHAUSTED   = 3'd2,
        ST_OUTSIDE     = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } t_status;

    // result of the shared word unit
    typedef struct packed {
        logic      found;
        t_bit_pos  pos;
        t_map_word word;
    } t_word_res;

    // block size in bytes and its log2
    localparam logic [SIZE_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
        32'd32, 32'd64, 32'd128, 32'd256, 32'd512, 32'd4096, 32'd16384
    };
    localparam logic [SHIFT_W-1:0] CLASS_SHIFT [NUM_CLASSES] = '{
        4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd12, 4'd14
    };
    localparam logic [COUNT_W-1:0] CLASS_BLOCKS [NUM_CLASSES] = '{
        10'd512, 10'd512, 10'd512, 10'd512, 10'd256, 10'd256, 10'd128
    };
    // byte offset of each class region within the pool, and its end
    localparam logic [OFS_W-1:0] REGION_START [NUM_CLASSES] = '{
        22'd0, 22'd16384, 22'd49152, 22'd114688, 22'd245760, 22'd376832, 22'd1425408
    };
    localparam logic [OFS_W-1:0] REGION_END [NUM_CLASSES] = '{
        22'd16384, 22'd49152, 22'd114688, 22'd245760, 22'd376832, 22'd1425408,
        22'd3522560
    };
    // first bitmap word of each class and the number of words it spans
    localparam logic [WORD_ADDR_W-1:0] BASE_WORD [NUM_CLASSES] = '{
        6'd0, 6'd8, 6'd16, 6'd24, 6'd32, 6'd36, 6'd40
    };
    localparam logic [WLEFT_W-1:0] CLASS_WORDS [NUM_CLASSES] = '{
        4'd8, 4'd8, 4'd8, 4'd8, 4'd4, 4'd4, 4'd2
    };

endpackage

// ===== rtl/core/scba_bitmap.sv =====
// used-block bitmap memory with per-word valid bits cleared by reset
module scba_bitmap (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rd_en,
    input  scba_pkg::t_word_addr  i_rd_addr,
    output scba_pkg::t_map_word   o_rd_data,
    input  logic                  i_wr_en,
    input  scba_pkg::t_word_addr  i_wr_addr,
    input  scba_pkg::t_map_word   i_wr_data
);

    scba_pkg::t_map_word               r_mem [scba_pkg::MAP_WORDS];
    logic [scba_pkg::MAP_WORDS-1:0]    r_valid;
    scba_pkg::t_map_word               r_rd_data;
    logic                              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // a word never written reads as all free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== rtl/core/scba_word_unit.sv =====
// shared word unit: first free bit search and bit set on allocate, bit test and clear on free
module scba_word_unit (
    input  scba_pkg::t_map_word  i_word,
    input  logic                 i_free,
    input  scba_pkg::t_bit_pos   i_pos,
    output scba_pkg::t_word_res  o_res
);

    always_comb begin
        o_res.found = 1'b0;
        o_res.pos   = i_pos;
        o_res.word  = i_word;
        if (i_free) begin
            o_res.found = i_word[i_pos];
            o_res.word  = i_word & ~(scba_pkg::t_map_word'(1) << i_pos);
        end else begin
            // lowest zero bit wins
            for (int b = scba_pkg::MAP_WORD_BITS - 1; b >= 0; b--) begin
                if (!i_word[b]) begin
                    o_res.found = 1'b1;
                    o_res.pos   = scba_pkg::t_bit_pos'(b);
                end
            end
            o_res.word = i_word | (scba_pkg::t_map_word'(1) << o_res.pos);
        end
    end

endmodule

// ===== rtl/core/size_class_bitmap_allocator.sv =====
// top level of the size class bitmap allocator: class search, sequencer and result registers
// allocate scans one bitmap word per cycle through the shared word unit (up to 8 words per class);
// free reads and updates a single word; oversize, outside pool and empty class end in the decode state
// throughput: one item at a time; o_busy falls with the strobe and a new item may then be taken
// reset: synchronous active low; clears pool base and bitmap valid bits and refills free counts at once;
// the receiver cannot stall results
module size_class_bitmap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_req_type,
    input  logic [31:0] i_request_size,
    input  logic [63:0] i_free_address,
    output logic        o_done,
    output logic [63:0] o_block_address,
    output logic [2:0]  o_status,
    output logic [2:0]  o_size_class,
    output logic [8:0]  o_block_index
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_LOCATE = 6'b000100,
        S_READ   = 6'b001000,
        S_SCAN   = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state                          r_state, n_state;
    logic [scba_pkg::ADDR_W-1:0]     r_pool_base;
    logic                            r_req_type, n_req_type;
    logic [scba_pkg::SIZE_W-1:0]     r_size, n_size;
    logic [scba_pkg::ADDR_W-1:0]     r_rel, n_rel;
    scba_pkg::t_class                r_cls, n_cls;
    scba_pkg::t_word_addr            r_word_addr, n_word_addr;
    scba_pkg::t_words_left           r_words_left, n_words_left;
    scba_pkg::t_bit_pos              r_bit, n_bit;
    scba_pkg::t_block_idx            r_index, n_index;
    scba_pkg::t_count                r_free_cnt [scba_pkg::NUM_CLASSES];
    scba_pkg::t_count                n_free_cnt [scba_pkg::NUM_CLASSES];
    logic                            r_done, n_done;
    logic [scba_pkg::ADDR_W-1:0]     r_block_address, n_block_address;
    scba_pkg::t_status               r_status, n_status;
    scba_pkg::t_class                r_size_class, n_size_class;
    scba_pkg::t_block_idx            r_block_index, n_block_index;

    logic                            rd_en;
    scba_pkg::t_word_addr            rd_addr;
    scba_pkg::t_map_word             rd_data;
    logic                            wr_en;
    scba_pkg::t_map_word             wr_data;
    scba_pkg::t_word_res             unit_res;

    logic                            hit;
    scba_pkg::t_class                hit_cls;
    scba_pkg::t_pool_ofs             loc_ofs;
    scba_pkg::t_pool_ofs             loc_blk;
    scba_pkg::t_word_addr            word_off;
    scba_pkg::t_pool_ofs             fin_ofs;

    scba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word_addr),
        .i_wr_data (wr_data)
    );

    scba_word_unit u_word_unit (
        .i_word (rd_data),
        .i_free (r_req_type),
        .i_pos  (r_bit),
        .o_res  (unit_res)
    );

    // class search: by size on allocate, by pool offset on free
    always_comb begin
        hit     = 1'b0;
        hit_cls = '0;
        for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            if (!hit) begin
                if (!r_req_type) begin
                    if (r_size <= scba_pkg::CLASS_BYTES[c]) begin
                        hit     = 1'b1;
                        hit_cls = scba_pkg::t_class'(c);
                    end
                end else if (r_rel[scba_pkg::ADDR_W-1:scba_pkg::OFS_W] == '0 &&
                             r_rel[scba_pkg::OFS_W-1:0] < scba_pkg::REGION_END[c]) begin
                    hit     = 1'b1;
                    hit_cls = scba_pkg::t_class'(c);
                end
            end
        end
    end

    assign loc_ofs  = r_rel[scba_pkg::OFS_W-1:0] - scba_pkg::REGION_START[r_cls];
    assign loc_blk  = loc_ofs >> scba_pkg::CLASS_SHIFT[r_cls];
    assign word_off = r_word_addr - scba_pkg::BASE_WORD[r_cls];
    assign fin_ofs  = scba_pkg::REGION_START[r_cls]
                    + (scba_pkg::t_pool_ofs'(r_index) << scba_pkg::CLASS_SHIFT[r_cls]);

    always_comb begin
        n_state         = r_state;
        n_req_type      = r_req_type;
        n_size          = r_size;
        n_rel           = r_rel;
        n_cls           = r_cls;
        n_word_addr     = r_word_addr;
        n_words_left    = r_words_left;
        n_bit           = r_bit;
        n_index         = r_index;
        n_free_cnt      = r_free_cnt;
        n_done          = 1'b0;
        n_block_address = r_block_address;
        n_status        = r_status;
        n_size_class    = r_size_class;
        n_block_index   = r_block_index;
        rd_en           = 1'b0;
        rd_addr         = r_word_addr;
        wr_en           = 1'b0;
        wr_data         = unit_res.word;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req_type = i_req_type;
                    n_size     = i_request_size;
                    n_rel      = i_free_address - r_pool_base;
                    n_bit      = '0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!hit) begin
                    n_done          = 1'b1;
                    n_block_address = '0;
                    n_status        = r_req_type ? scba_pkg::ST_OUTSIDE
                                                 : scba_pkg::ST_TOO_LARGE;
                    n_size_class    = '0;
                    n_block_index   = '0;
                    n_state         = S_IDLE;
                end else if (r_req_type) begin
                    n_cls   = hit_cls;
                    n_state = S_LOCATE;
                end else if (r_free_cnt[hit_cls] == '0) begin
                    n_done          = 1'b1;
                    n_block_address = '0;
                    n_status        = scba_pkg::ST_EXHAUSTED;
                    n_size_class    = hit_cls;
                    n_block_index   = '0;
                    n_state         = S_IDLE;
                end else begin
                    n_cls        = hit_cls;
                    n_word_addr  = scba_pkg::BASE_WORD[hit_cls];
                    n_words_left = scba_pkg::CLASS_WORDS[hit_cls];
                    n_state      = S_READ;
                end
            end
            S_LOCATE: begin
                // unaligned addresses land in the block that holds them
                n_index      = loc_blk[scba_pkg::INDEX_W-1:0];
                n_bit        = loc_blk[scba_pkg::BIT_POS_W-1:0];
                n_word_addr  = scba_pkg::BASE_WORD[r_cls]
                             + scba_pkg::t_word_addr'(
                                   loc_blk[scba_pkg::INDEX_W-1:scba_pkg::BIT_POS_W]);
                n_words_left = scba_pkg::t_words_left'(1);
                n_state      = S_READ;
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_req_type) begin
                    n_done          = 1'b1;
                    n_block_address = '0;
                    n_size_class    = r_cls;
                    n_block_index   = r_index;
                    n_state         = S_IDLE;
                    if (unit_res.found) begin
                        wr_en             = 1'b1;
                        n_free_cnt[r_cls] = r_free_cnt[r_cls] + scba_pkg::t_count'(1);
                        n_status          = scba_pkg::ST_OK;
                    end else begin
                        n_status = scba_pkg::ST_DOUBLE_FREE;
                    end
                end else if (unit_res.found) begin
                    wr_en             = 1'b1;
                    n_free_cnt[r_cls] = r_free_cnt[r_cls] - scba_pkg::t_count'(1);
                    n_index           = {word_off[scba_pkg::INDEX_W-scba_pkg::BIT_POS_W-1:0],
                                         unit_res.pos};
                    n_state           = S_FINISH;
                end else if (r_words_left == scba_pkg::t_words_left'(1)) begin
                    n_done          = 1'b1;
                    n_block_address = '0;
                    n_status        = scba_pkg::ST_EXHAUSTED;
                    n_size_class    = r_cls;
                    n_block_index   = '0;
                    n_state         = S_IDLE;
                end else begin
                    // fetch the next word while this one is examined
                    rd_en        = 1'b1;
                    rd_addr      = r_word_addr + scba_pkg::t_word_addr'(1);
                    n_word_addr  = rd_addr;
                    n_words_left = r_words_left - scba_pkg::t_words_left'(1);
                end
            end
            S_FINISH: begin
                n_done          = 1'b1;
                n_block_address = r_pool_base + scba_pkg::ADDR_W'(fin_ofs);
                n_status        = scba_pkg::ST_OK;
                n_size_class    = r_cls;
                n_block_index   = r_index;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool_base <= '0;
            r_done      <= 1'b0;
            for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
                r_free_cnt[c] <= scba_pkg::CLASS_BLOCKS[c];
            end
        end else begin
            r_state    <= n_state;
            r_done     <= n_done;
            r_free_cnt <= n_free_cnt;
            if (i_cfg_wr_en) begin
                r_pool_base <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type      <= n_req_type;
        r_size          <= n_size;
        r_rel           <= n_rel;
        r_cls           <= n_cls;
        r_word_addr     <= n_word_addr;
        r_words_left    <= n_words_left;
        r_bit           <= n_bit;
        r_index         <= n_index;
        r_block_address <= n_block_address;
        r_status        <= n_status;
        r_size_class    <= n_size_class;
        r_block_index   <= n_block_index;
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_block_address = r_block_address;
    assign o_status        = r_status;
    assign o_size_class    = r_size_class;
    assign o_block_index   = r_block_index;

endmodule

// ===== dv/tb_top.sv =====
// testbench for the size class bitmap allocator: directed and random items against a predictor
module tb_top;

    localparam int          NCLS         = 7;
    localparam int          BLOCKS_TOTAL = 2688;
    localparam logic [63:0] POOL_BYTES   = 64'd3522560;

    typedef struct packed {
        logic [63:0]       block_address;
        scba_pkg::t_status status;
        logic [2:0]        size_class;
        logic [8:0]        block_index;
    } t_alloc_result;

    typedef struct {
        int cls;
        int idx;
    } t_blk_ref;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wr_en    = 1'b0;
    logic [63:0] i_cfg_wr_data  = 64'd0;
    logic        i_start        = 1'b0;
    logic        i_req_type     = 1'b0;
    logic [31:0] i_request_size = 32'd0;
    logic [63:0] i_free_address = 64'd0;
    logic        o_busy;
    logic        o_done;
    logic [63:0] o_block_address;
    logic [2:0]  o_status;
    logic [2:0]  o_size_class;
    logic [8:0]  o_block_index;

    // predictor state
    logic [63:0]   pool_base_q;
    bit            blk_used [BLOCKS_TOTAL];
    logic [9:0]    free_cnt [NCLS];
    t_alloc_result pending_results [$];
    t_blk_ref      live_blocks [$];
    t_blk_ref      freed_blocks [$];

    int error_count = 0;
    int max_gap     = 14;

    size_class_bitmap_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_req_type     (i_req_type),
        .i_request_size (i_request_size),
        .i_free_address (i_free_address),
        .o_done         (o_done),
        .o_block_address(o_block_address),
        .o_status       (o_status),
        .o_size_class   (o_size_class),
        .o_block_index  (o_block_index)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [63:0] blk_bytes(input int c);
        case (c)
            0: return 64'd32;
            1: return 64'd64;
            2: return 64'd128;
            3: return 64'd256;
            4: return 64'd512;
            5: return 64'd4096;
            default: return 64'd16384;
        endcase
    endfunction

    function automatic logic [63:0] blk_count(input int c);
        case (c)
            0, 1, 2, 3: return 64'd512;
            4, 5: return 64'd256;
            default: return 64'd128;
        endcase
    endfunction

    function automatic logic [63:0] blk_addr(input t_blk_ref b);
        logic [63:0] ofs;
        int k;
        ofs = 64'd0;
        for (k = 0; k < b.cls; k++) ofs += blk_bytes(k) * blk_count(k);
        return pool_base_q + ofs + 64'(b.idx) * blk_bytes(b.cls);
    endfunction

    // address inside a live block, at its start or somewhere within it
    function automatic logic [63:0] live_addr(input int j);
        t_blk_ref b;
        b = live_blocks[j];
        if ($urandom_range(0, 1) == 0) return blk_addr(b);
        return blk_addr(b) + 64'($urandom_range(0, int'(blk_bytes(b.cls)) - 1));
    endfunction

    function automatic logic [31:0] rand_size();
        int c;
        c = $urandom_range(0, NCLS - 1);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'($urandom_range(16385, 40000));
            2: return $urandom;
            3: return 32'(blk_bytes(c)) + 32'($urandom_range(0, 1));
            default: begin
                if (c == 0) return 32'($urandom_range(0, 32));
                return 32'($urandom_range(int'(blk_bytes(c - 1)) + 1, int'(blk_bytes(c))));
            end
        endcase
    endfunction

    function automatic void forget_live(input int cls, input int idx);
        int k;
        for (k = 0; k < live_blocks.size(); k++) begin
            if (live_blocks[k].cls == cls && live_blocks[k].idx == idx) begin
                live_blocks.delete(k);
                return;
            end
        end
    endfunction

    // works out the result of one accepted item and updates the allocator state
    function automatic void predict_result(input bit is_free, input logic [31:0] req_size,
                                           input logic [63:0] free_addr);
        t_alloc_result r;
        logic [63:0]   skip, len, rel, n;
        int            first_blk, c, cls_i, k;
        bit            found;
        t_blk_ref      b;
        r.block_address = 64'd0;
        r.status        = scba_pkg::ST_OK;
        r.size_class    = 3'd0;
        r.block_index   = 9'd0;
        skip      = 64'd0;
        first_blk = 0;
        found     = 1'b0;
        cls_i     = 0;
        if (!is_free) begin
            for (c = 0; c < NCLS; c++) begin
                if (!found && 64'(req_size) <= blk_bytes(c)) begin
                    found = 1'b1;
                    cls_i = c;
                end else if (!found) begin
                    skip      += blk_bytes(c) * blk_count(c);
                    first_blk += int'(blk_count(c));
                end
            end
            if (!found) begin
                r.status = scba_pkg::ST_TOO_LARGE;
            end else begin
                r.size_class = 3'(cls_i);
                r.status     = scba_pkg::ST_EXHAUSTED;
                if (free_cnt[cls_i] != 10'd0) begin
                    for (k = 0; k < int'(blk_count(cls_i)); k++) begin
                        if (r.status == scba_pkg::ST_EXHAUSTED && !blk_used[first_blk + k]) begin
                            blk_used[first_blk + k] = 1'b1;
                            free_cnt[cls_i]         = free_cnt[cls_i] - 10'd1;
                            r.status        = scba_pkg::ST_OK;
                            r.block_index   = 9'(k);
                            r.block_address = pool_base_q + skip + 64'(k) * blk_bytes(cls_i);
                            b.cls = cls_i;
                            b.idx = k;
                            live_blocks.push_back(b);
                        end
                    end
                end
            end
        end else begin
            rel = free_addr - pool_base_q;
            for (c = 0; c < NCLS; c++) begin
                len = blk_bytes(c) * blk_count(c);
                if (!found && rel < skip + len) begin
                    found = 1'b1;
                    cls_i = c;
                end else if (!found) begin
                    skip      += len;
                    first_blk += int'(blk_count(c));
                end
            end
            if (!found) begin
                r.status = scba_pkg::ST_OUTSIDE;
            end else begin
                n = (rel - skip) / blk_bytes(cls_i);
                r.size_class  = 3'(cls_i);
                r.block_index = 9'(n);
                if (!blk_used[first_blk + int'(n)]) begin
                    r.status = scba_pkg::ST_DOUBLE_FREE;
                end else begin
                    blk_used[first_blk + int'(n)] = 1'b0;
                    free_cnt[cls_i] = free_cnt[cls_i] + 10'd1;
                    forget_live(cls_i, int'(n));
                    b.cls = cls_i;
                    b.idx = int'(n);
                    freed_blocks.push_back(b);
                    if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
                end
            end
        end
        pending_results.push_back(r);
    endfunction

    // one item through the start/busy handshake, after a random gap
    task automatic send_item(input bit is_free, input logic [31:0] req_size,
                             input logic [63:0] free_addr);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start        <= 1'b1;
        i_req_type     <= is_free;
        i_request_size <= req_size;
        i_free_address <= free_addr;
        do @(posedge i_clk); while (o_busy);
        predict_result(is_free, req_size, free_addr);
    endtask

    task automatic alloc_item(input logic [31:0] req_size);
        send_item(1'b0, req_size, {$urandom, $urandom});
    endtask

    task automatic free_item(input logic [63:0] free_addr);
        send_item(1'b1, $urandom, free_addr);
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_pool_base(input logic [63:0] base);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= base;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pool_base_q    = base;
    endtask

    // class boundaries, zero size and oversize requests at the reset pool base
    task automatic test_alloc_classes();
        alloc_item(32'd0);
        alloc_item(32'd1);
        alloc_item(32'd32);
        alloc_item(32'd33);
        alloc_item(32'd64);
        alloc_item(32'd65);
        alloc_item(32'd128);
        alloc_item(32'd256);
        alloc_item(32'd257);
        alloc_item(32'd512);
        alloc_item(32'd513);
        alloc_item(32'd4096);
        alloc_item(32'd4097);
        alloc_item(32'd16384);
        alloc_item(32'd16385);
        alloc_item(32'hFFFF_FFFF);
    endtask

    // unaligned, double and outside frees
    task automatic test_free_cases();
        free_item(64'd5);
        free_item(64'd0);
        free_item(64'd1425408 + 64'd16383);
        free_item(POOL_BYTES);
        free_item(POOL_BYTES - 64'd1);
        free_item(64'hFFFF_FFFF_FFFF_FFFF);
        free_item(64'd376832);
        set_pool_base(64'hFFFF_FFFF_FFFF_FFFF);
        alloc_item(32'd0);
        free_item(pool_base_q - 64'd1);
        if (live_blocks.size() != 0) free_item(blk_addr(live_blocks[live_blocks.size() - 1]));
    endtask

    // fill the largest class past its end, then give every block back
    task automatic test_class_exhaustion();
        int picks[$];
        int k;
        set_pool_base(64'h0000_7FFF_0000_1000);
        max_gap = 0;
        repeat (131) alloc_item(32'($urandom_range(4097, 16384)));
        max_gap = 14;
        while (1) begin
            picks.delete();
            for (k = 0; k < live_blocks.size(); k++)
                if (live_blocks[k].cls == NCLS - 1) picks.push_back(k);
            if (picks.size() == 0) break;
            free_item(live_addr(picks[$urandom_range(0, picks.size() - 1)]));
        end
    endtask

    // mostly allocations and frees of live blocks, with broken frees mixed in
    task automatic test_random_traffic(input int n_items);
        int i, kind;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: max_gap = 0;
                    1: max_gap = 3;
                    default: max_gap = 14;
                endcase
            end
            if (i == n_items / 2) wait_drained();
            kind = $urandom_range(0, 99);
            if (kind < 50 || (kind < 78 && live_blocks.size() == 0)) begin
                alloc_item(rand_size());
            end else if (kind < 78) begin
                free_item(live_addr($urandom_range(0, live_blocks.size() - 1)));
            end else if (kind < 86 && freed_blocks.size() != 0) begin
                free_item(blk_addr(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]));
            end else if (kind < 93) begin
                if ($urandom_range(0, 1) == 0)
                    free_item(pool_base_q + POOL_BYTES + 64'($urandom_range(0, 1 << 20)));
                else
                    free_item(pool_base_q - 64'd1 - 64'($urandom_range(0, 1 << 20)));
            end else begin
                free_item({$urandom, $urandom});
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_alloc_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual addr %h status %0d",
                         $time, o_block_address, o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_block_address !== want.block_address) begin
                    $display("%0t: block_address mismatch, expected %h, actual %h",
                             $time, want.block_address, o_block_address);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_size_class !== want.size_class) begin
                    $display("%0t: size_class mismatch, expected %0d, actual %0d",
                             $time, want.size_class, o_size_class);
                    error_count++;
                end
                if (o_block_index !== want.block_index) begin
                    $display("%0t: block_index mismatch, expected %0d, actual %0d",
                             $time, want.block_index, o_block_index);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int c;
        pool_base_q = 64'd0;
        for (c = 0; c < BLOCKS_TOTAL; c++) blk_used[c] = 1'b0;
        for (c = 0; c < NCLS; c++) free_cnt[c] = 10'(blk_count(c));
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_alloc_classes();
        test_free_cases();
        test_class_exhaustion();
        set_pool_base(64'hFFFF_FFFF_FFE0_0000);
        test_random_traffic(105);
        set_pool_base({$urandom, $urandom});
        test_random_traffic(105);
        set_pool_base(64'hFFFF_FFFF_FFFF_FFFF);
        test_random_traffic(105);
        set_pool_base(64'd0);
        test_random_traffic(105);
        wait_drained();
        repeat (4) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
